// ===== rtl/core/ist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants of the integer set table
// Command and status codes, the sequencer state type and the item records
// that pass between the top level and the sequencer.
// ----------------------------------------------------------------------------
package ist_pkg;

	localparam int CMD_W     = 2;
	localparam int IN_VAL_W  = 32;
	localparam int IDX_W     = 4;
	localparam int CNT_OUT_W = 5;
	localparam int STATUS_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_SHIFT,
		S_RDWAIT,
		S_RESP
	} state_t;

	typedef struct packed {
		cmd_t                        cmd;
		logic signed [IN_VAL_W-1:0]  item_value;
		logic [IDX_W-1:0]            read_index;
	} req_item_t;

	typedef struct packed {
		logic                        was_present;
		logic [CNT_OUT_W-1:0]        entry_count;
		logic signed [IN_VAL_W-1:0]  entry_value;
		status_t                     status;
	} rsp_item_t;

endpackage

// ===== rtl/core/ist_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_if: item channels of the integer set table
// Command channel and result channel, each a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ist_req_if import ist_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [CMD_W-1:0]            cmd;
	logic signed [IN_VAL_W-1:0]  item_value;
	logic [IDX_W-1:0]            read_index;

	modport source (output valid, output cmd, output item_value, output read_index,
		input ready);
	modport sink (input valid, input cmd, input item_value, input read_index,
		output ready);
endinterface

interface ist_rsp_if import ist_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        was_present;
	logic [CNT_OUT_W-1:0]        entry_count;
	logic signed [IN_VAL_W-1:0]  entry_value;
	logic [STATUS_W-1:0]         status;

	modport source (output valid, output was_present, output entry_count,
		output entry_value, output status, input ready);
	modport sink (input valid, input was_present, input entry_count,
		input entry_value, input status, output ready);
endinterface

// ===== rtl/core/integer_set_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_set_table_core: set of distinct integers kept in insertion order
// Add appends an absent value, remove deletes and compacts, query reports
// membership, read returns the entry at an index.
// ----------------------------------------------------------------------------
// Sequence: every item runs the membership scan, then S_EXEC; a remove that
//   finds its value adds the compacting shift, a valid read adds S_RDWAIT.
// Items: one at a time, the next accepted the cycle after the result
//   is registered; the scan and the shift grow with the fill count.
// Reset: arst_n clears the fill count and the control state at once; the
//   entry store is not cleared and needs no clearing pass.
module integer_set_table_core import ist_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ist_req_if.sink    req,
	ist_rsp_if.source  rsp
);

	req_item_t req_data;
	rsp_item_t seq_res;
	rsp_item_t rsp_q;
	logic      rsp_valid_q;
	logic      room;
	logic      seq_done;

	// gather the command channel into one record
	always_comb begin
		req_data.cmd        = cmd_t'(req.cmd);
		req_data.item_value = req.item_value;
		req_data.read_index = req.read_index;
	end

	// the output slot can take a new result when empty or being drained
	assign room = !rsp_valid_q || rsp.ready;

	ist_seq #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_data  (req_data),
		.res_room  (room),
		.res_done  (seq_done),
		.res_data  (seq_res)
	);

	// result register: hold until taken, so the sequencer may start the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (seq_done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			rsp_q <= seq_res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.was_present = rsp_q.was_present;
	assign rsp.entry_count = rsp_q.entry_count;
	assign rsp.entry_value = rsp_q.entry_value;
	assign rsp.status      = rsp_q.status;

`ifndef SYNTH
	a_done_room: assert property (@(posedge clk) disable iff (!arst_n)
		seq_done |-> room)
		else $error("result finished with no room in the output register");

	a_full_absent: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FULL) |-> !rsp.was_present)
		else $error("dropped add reports a present value");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_RANGE) |-> (rsp.entry_value == '0))
		else $error("failed read returns a nonzero entry");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("command accepted while one is in progress");
`endif

endmodule

// ===== rtl/core/ist_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_mem: entry store
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ist_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/ist_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_seq: command sequencer of the integer set table
// Scans the store for the value, then appends, compacts or reads an entry.
// ----------------------------------------------------------------------------
module ist_seq import ist_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req_data,
	input  logic      res_room,
	output logic      res_done,
	output rsp_item_t res_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t                state_q, state_d;
	cmd_t                  cmd_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [IDX_W-1:0]      idx_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         ptr_q;
	logic                  pend_q;
	logic [AW-1:0]         pa_q;
	logic                  found_q;
	logic [AW-1:0]         pos_q;
	status_t               status_q;
	logic [VALUE_BITS-1:0] value_q;

	logic                  rd_en, wr_en;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic [VALUE_BITS-1:0] rd_data, wr_data;

	logic more, hit, scan_end, idx_ok, full;

	assign more     = (ptr_q < cnt_q);
	assign hit      = pend_q && (rd_data == val_q);
	assign scan_end = hit || !more;
	assign idx_ok   = int'(idx_q) < int'(cnt_q);
	assign full     = (cnt_q == CW'(CAPACITY));

	ist_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_end) state_d = S_EXEC;
			end
			S_EXEC: begin
				unique case (cmd_q)
					CMD_REMOVE: state_d = found_q ? S_SHIFT : S_RESP;
					CMD_READ:   state_d = idx_ok ? S_RDWAIT : S_RESP;
					default:    state_d = S_RESP;
				endcase
			end
			S_SHIFT: begin
				if (!more) state_d = S_RESP;
			end
			S_RDWAIT: state_d = S_RESP;
			S_RESP: begin
				if (res_room) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		res_done  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = ptr_q[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = cnt_q[AW-1:0];
		wr_data   = val_q;
		unique case (state_q)
			S_IDLE: req_ready = 1'b1;
			S_SCAN: rd_en = more;
			S_EXEC: begin
				if (cmd_q == CMD_ADD && !found_q && !full) wr_en = 1'b1;
				if (cmd_q == CMD_READ && idx_ok) begin
					rd_en   = 1'b1;
					rd_addr = AW'(idx_q);
				end
			end
			S_SHIFT: begin
				// read the next entry, write the one read last cycle one slot down
				rd_en   = more;
				wr_en   = pend_q;
				wr_addr = pa_q - AW'(1);
				wr_data = rd_data;
			end
			S_RESP: res_done = res_room;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						ptr_q  <= '0;
						pend_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (more) ptr_q <= ptr_q + CW'(1);
					pend_q <= more;
				end
				S_EXEC: begin
					if (cmd_q == CMD_ADD && !found_q && !full) cnt_q <= cnt_q + CW'(1);
					ptr_q  <= CW'(pos_q) + CW'(1);
					pend_q <= 1'b0;
				end
				S_SHIFT: begin
					if (more) ptr_q <= ptr_q + CW'(1);
					pend_q <= more;
					if (!more) cnt_q <= cnt_q - CW'(1);
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd_q    <= req_data.cmd;
					val_q    <= VALUE_BITS'(req_data.item_value);
					idx_q    <= req_data.read_index;
					found_q  <= 1'b0;
					status_q <= ST_OK;
					value_q  <= '0;
				end
			end
			S_SCAN: begin
				pa_q <= ptr_q[AW-1:0];
				if (hit) begin
					found_q <= 1'b1;
					pos_q   <= pa_q;
				end
			end
			S_EXEC: begin
				if (cmd_q == CMD_ADD && !found_q && full) status_q <= ST_FULL;
				if (cmd_q == CMD_READ && !idx_ok) status_q <= ST_RANGE;
			end
			S_SHIFT: pa_q <= ptr_q[AW-1:0];
			S_RDWAIT: value_q <= rd_data;
			default: ;
		endcase
	end

	always_comb begin
		res_data.was_present = found_q;
		res_data.entry_count = CNT_OUT_W'(cnt_q);
		res_data.entry_value = IN_VAL_W'(value_q);
		res_data.status      = status_q;
	end

endmodule
